@@ hw/rtl/adl_pkg.sv @@
// Shared types, constants and arctangent table for the arctan distortion block.
`default_nettype none
package adl_pkg;
    localparam int SAMPLE_W = 24;
    localparam int CTRL_W   = 18;
    localparam int OUT_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int Z_W      = 22;
    localparam int XY_W     = 28;
    localparam int TABLE_LEN = 30;
    localparam int STEP_W   = 5;

    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_VALUE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE_VALUE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_SEL   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE_SEL   = 2'd3;

    localparam logic [19:0] D_OFFSET = 20'd419430;
    localparam logic [18:0] D_SCALE  = 19'd419326;
    localparam logic [16:0] ONE_Q16  = 17'd65536;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_CORDIC, ST_FB, ST_SUM, ST_OUT
    } t_state;

    function automatic logic [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic [Z_W-1:0] v;
        case (i)
            5'd0: v = 22'd823550;
            5'd1: v = 22'd486170;
            5'd2: v = 22'd256879;
            5'd3: v = 22'd130396;
            5'd4: v = 22'd65451;
            5'd5: v = 22'd32757;
            5'd6: v = 22'd16383;
            5'd7: v = 22'd8192;
            5'd8: v = 22'd4096;
            5'd9: v = 22'd2048;
            5'd10: v = 22'd1024;
            5'd11: v = 22'd512;
            5'd12: v = 22'd256;
            5'd13: v = 22'd128;
            5'd14: v = 22'd64;
            5'd15: v = 22'd32;
            5'd16: v = 22'd16;
            5'd17: v = 22'd8;
            5'd18: v = 22'd4;
            5'd19: v = 22'd2;
            5'd20: v = 22'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] clip_unit(input logic signed [CTRL_W-1:0] v);
        logic [16:0] r;
        if (v[CTRL_W-1]) r = '0;
        else if (v > $signed({1'b0, ONE_Q16})) r = ONE_Q16;
        else r = v[16:0];
        return r;
    endfunction
endpackage
`default_nettype wire

@@ hw/rtl/adl_cordic.sv @@
// Iterative vectoring CORDIC: one micro-rotation per cycle.
`default_nettype none
module adl_cordic
    import adl_pkg::*;
#(
    parameter int STEPS = 20
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire signed [SAMPLE_W-1:0]  i_y,
    input  wire        [19:0]          i_x,
    output logic                       o_done,
    output logic signed [Z_W-1:0]      o_z
);
    logic signed [XY_W-1:0] r_x, n_x, r_y, n_y;
    logic signed [Z_W-1:0]  r_z, n_z;
    logic [STEP_W-1:0]      r_i, n_i;
    logic                   r_busy, n_busy;
    logic signed [XY_W-1:0] xs, ys;
    logic [Z_W-1:0]         ang;

    assign xs  = r_x >>> r_i;
    assign ys  = r_y >>> r_i;
    assign ang = atan_entry(r_i);

    always_comb begin
        n_x = r_x; n_y = r_y; n_z = r_z; n_i = r_i; n_busy = r_busy;
        o_done = 1'b0;
        if (i_start) begin
            n_x = XY_W'(i_x);
            n_y = XY_W'(i_y);
            n_z = '0;
            n_i = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!r_y[XY_W-1]) begin
                n_x = r_x + ys; n_y = r_y - xs; n_z = r_z + $signed(ang);
            end else begin
                n_x = r_x - ys; n_y = r_y + xs; n_z = r_z - $signed(ang);
            end
            n_i = r_i + 1'b1;
            if (r_i == STEP_W'(STEPS - 1)) begin
                n_busy = 1'b0;
                o_done = 1'b1;
            end
        end
    end

    assign o_z = n_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i <= '0;
        end else begin
            r_busy <= n_busy;
            r_i <= n_i;
        end
        r_x <= n_x; r_y <= n_y; r_z <= n_z;
    end
endmodule
`default_nettype wire

@@ hw/rtl/adl_serial_mul.sv @@
// Bit-serial shift-add multiplier: signed multiplicand times unsigned 17-bit multiplier.
`default_nettype none
module adl_serial_mul
    import adl_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire signed [OUT_W-1:0] i_a,
    input  wire        [16:0]   i_b,
    output logic                o_done,
    output logic signed [49:0]  o_p
);
    logic signed [49:0] r_acc, n_acc, r_a, n_a;
    logic [16:0]        r_b, n_b;
    logic [4:0]         r_cnt, n_cnt;
    logic               r_busy, n_busy;

    always_comb begin
        n_acc = r_acc; n_a = r_a; n_b = r_b; n_cnt = r_cnt; n_busy = r_busy;
        o_done = 1'b0;
        if (i_start) begin
            n_acc = '0; n_a = 50'(i_a); n_b = i_b; n_cnt = '0; n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_b[0]) n_acc = r_acc + r_a;
            n_a = r_a <<< 1;
            n_b = r_b >> 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == 5'd16) begin
                n_busy = 1'b0;
                o_done = 1'b1;
            end
        end
    end

    // the product is complete in the cycle that raises o_done
    assign o_p = n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt <= n_cnt;
        end
        r_acc <= n_acc; r_a <= n_a; r_b <= n_b;
    end
endmodule
`default_nettype wire

@@ hw/rtl/arctan_distortion_lowpass_unit.sv @@
// Top level: arctan waveshaper with one-pole feedback, stream in and out.
// Usage: a sample enters on the s_axis group; tdata holds sample [23:0],
// drive_sample [41:24], slope_sample [59:42], zero fill to 64 bits.
// The result leaves on the m_axis group; tdata holds out_sample [31:0].
// Registers are written on i_cfg_we with index i_cfg_idx: 0 drive_value,
// 1 slope_value, 2 drive_from_input, 3 slope_from_input.
// One item is in flight at a time. From input transfer to a valid result the
// item passes the serial drive multiplier (d = 0.4 - 0.3999*drive), the
// CORDIC iterations, the serial slope multiplier (feedback), then the sum
// state and the output register state; the wait is set by the two bit-serial
// multipliers and the CORDIC iterations. No new item is taken before the last
// one is through: the next item is taken once the result has been moved into
// the output register, and that move waits while a stalled receiver still
// holds an earlier result there.
// At reset registers take their defaults, the feedback state is zero
// and both channels are empty.
`default_nettype none
module arctan_distortion_lowpass_unit
    import adl_pkg::*;
#(
    parameter int CORDIC_STEPS = 20
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [63:0]  s_axis_tdata,  // sample, drive_sample, slope_sample
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [31:0]  m_axis_tdata,  // out_sample
    input  wire          i_cfg_we,
    input  wire  [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire  [CTRL_W-1:0]    i_cfg_data
);
    localparam int STEPS_USED = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    logic [CTRL_W-1:0] r_drive_value, r_slope_value;
    logic r_drive_sel, r_slope_sel;
    t_state r_state, n_state;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [16:0] r_slp;
    logic signed [OUT_W-1:0] r_prev, r_out;
    logic r_out_valid;
    logic [19:0] r_d;
    logic signed [Z_W-1:0] r_z;
    logic signed [OUT_W+1:0] r_fb;

    logic accept;
    logic mul_start, mul_done, cor_start, cor_done;
    logic signed [OUT_W-1:0] mul_a;
    logic [16:0] mul_b;
    logic signed [49:0] mul_p;
    logic signed [Z_W-1:0] cor_z;
    logic signed [OUT_W+1:0] sum;
    logic signed [OUT_W-1:0] sat;
    logic [16:0] drv_in, slp_in;
    logic [19:0] d_calc;

    assign drv_in = clip_unit(r_drive_sel ? s_axis_tdata[41:24] : r_drive_value);
    assign slp_in = clip_unit(r_slope_sel ? s_axis_tdata[59:42] : r_slope_value);
    assign accept = s_axis_tvalid && s_axis_tready;

    // divisor straight from the multiplier so the CORDIC loads it on the same edge
    assign d_calc = D_OFFSET - 20'((mul_p + 50'sd32768) >>> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_value <= 18'd49152;
            r_slope_value <= 18'd32768;
            r_drive_sel <= 1'b0;
            r_slope_sel <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DRIVE_VALUE: r_drive_value <= i_cfg_data;
                REG_SLOPE_VALUE: r_slope_value <= i_cfg_data;
                REG_DRIVE_SEL:   r_drive_sel <= i_cfg_data[0];
                REG_SLOPE_SEL:   r_slope_sel <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // One serial multiplier serves drive scaling and feedback.
    adl_serial_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(mul_a), .i_b(mul_b), .o_done(mul_done), .o_p(mul_p)
    );

    adl_cordic #(.STEPS(STEPS_USED)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cor_start),
        .i_y(r_sample), .i_x(d_calc), .o_done(cor_done), .o_z(cor_z)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (accept) n_state = ST_DIV;
            ST_DIV:    if (mul_done) n_state = ST_CORDIC;
            ST_CORDIC: if (cor_done) n_state = ST_FB;
            ST_FB:     if (mul_done) n_state = ST_SUM;
            ST_SUM:    n_state = ST_OUT;
            ST_OUT:    if (!r_out_valid || m_axis_tready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        mul_start = 1'b0;
        cor_start = 1'b0;
        mul_a = r_prev;
        mul_b = r_slp;
        unique case (r_state)
            ST_IDLE: begin
                mul_start = accept;
                mul_a = OUT_W'($signed({1'b0, D_SCALE}));
                mul_b = drv_in;
            end
            ST_DIV:    cor_start = mul_done;
            ST_CORDIC: mul_start = cor_done;
            default: ;
        endcase
    end

    assign sum = (OUT_W+2)'(r_z) + r_fb;
    assign sat = (sum > (OUT_W+2)'(33'sh0_7FFF_FFFF)) ? 32'sh7FFF_FFFF :
                 (sum < -(OUT_W+2)'(34'sd2147483648)) ? 32'sh8000_0000 :
                 sum[OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_prev <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SUM) r_prev <= sat;
            if (r_state == ST_OUT && (!r_out_valid || m_axis_tready))
                r_out_valid <= 1'b1;
            else if (m_axis_tready)
                r_out_valid <= 1'b0;
        end
        if (accept) begin
            r_sample <= s_axis_tdata[23:0];
            r_slp <= slp_in;
        end
        if (r_state == ST_DIV && mul_done)
            r_d <= d_calc;
        if (cor_done) r_z <= cor_z;
        if (r_state == ST_FB && mul_done)
            r_fb <= (OUT_W+2)'((mul_p + 50'sd32768) >>> 16);
        if (r_state == ST_OUT && (!r_out_valid || m_axis_tready)) r_out <= r_prev;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = r_out;

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result lost under stall");
    a_d_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CORDIC) |-> (r_d >= 20'd104))
        else $error("divisor out of range");
endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the arctan distortion unit with feedback.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import adl_pkg::*;

    localparam int STEPS = 20;
    localparam int STALL_LIMIT = 20000;
    localparam int N_RANDOM = 1530;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [63:0] s_axis_tdata = '0;  // sample, drive_sample, slope_sample
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;       // out_sample
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CTRL_W-1:0] i_cfg_data = '0;

    arctan_distortion_lowpass_unit #(.CORDIC_STEPS(STEPS)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    typedef struct packed {
        logic signed [CTRL_W-1:0]   slope;
        logic signed [CTRL_W-1:0]   drive;
        logic signed [SAMPLE_W-1:0] sample;
    } t_item;

    typedef struct {
        t_item       item;
        logic        has_fixed;
        logic [31:0] fixed_out;
    } t_row;

    // predictor state and register shadow
    logic signed [CTRL_W-1:0] drive_reg, slope_reg;
    logic drive_sel, slope_sel;
    longint prev_out;

    logic [31:0] expected_out[$];
    int errors = 0;
    int idle_cycles = 0;
    bit sender_hold = 1'b0;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v < 0) return 0;
        if (v > 65536) return 65536;
        return v;
    endfunction

    function automatic longint atan_step(int i);
        longint angles[21] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
            8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
        return (i < 21) ? angles[i] : 0;
    endfunction

    function automatic logic [31:0] shape_sample(t_item it);
        longint drv, slp, x, y, z, xs, ys, fb, sum;
        drv = clamp_unit(drive_sel ? longint'(it.drive) : longint'(drive_reg));
        slp = clamp_unit(slope_sel ? longint'(it.slope) : longint'(slope_reg));
        x = 419430 - ((drv * 419326 + 32768) >>> 16);
        y = it.sample;
        z = 0;
        for (int i = 0; i < STEPS; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + atan_step(i);
            end else begin
                x = x - ys; y = y + xs; z = z - atan_step(i);
            end
        end
        fb = floor_shift(prev_out * slp + 32768, 16);
        sum = z + fb;
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        prev_out = sum;
        return sum[31:0];
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t",
                 what, $signed(got), $signed(want), $realtime);
        errors++;
    endtask

    // receiver: stall pattern and output check
    int stall_phase = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            stall_phase <= stall_phase + 1;
            m_axis_tready <= (stall_phase % 256 < 64) ? 1'b1 : ($urandom_range(0, 3) != 0);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_out.size() == 0)
                    report_mismatch("unexpected transfer", m_axis_tdata, 32'd0);
                else begin
                    if (m_axis_tdata !== expected_out[0])
                        report_mismatch("out_sample", m_axis_tdata, expected_out[0]);
                    void'(expected_out.pop_front());
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CTRL_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_DRIVE_VALUE: drive_reg = val;
            REG_SLOPE_VALUE: slope_reg = val;
            REG_DRIVE_SEL:   drive_sel = val[0];
            REG_SLOPE_SEL:   slope_sel = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (STEPS + 45) @(posedge i_clk);
    endtask

    // send one item; tvalid stays up so the next item follows without a gap
    task automatic send_sample(t_item it, logic has_fixed, logic [31:0] fixed_out);
        logic [31:0] want;
        want = shape_sample(it);
        if (has_fixed && want !== fixed_out)
            report_mismatch("directed table", want, fixed_out);
        s_axis_tdata <= {4'd0, it.slope, it.drive, it.sample};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_out.push_back(want);
    endtask

    task automatic random_gap();
        if ($urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    endtask

    function automatic t_item rand_item();
        t_item it;
        int pick;
        it.sample = SAMPLE_W'($urandom);
        it.drive = CTRL_W'($urandom);
        it.slope = CTRL_W'($urandom);
        pick = $urandom_range(0, 9);
        // mostly in-range controls so clipping does not dominate
        if (pick < 6) it.drive = CTRL_W'($urandom_range(0, 65536));
        pick = $urandom_range(0, 9);
        if (pick < 6) it.slope = CTRL_W'($urandom_range(0, 65536));
        if ($urandom_range(0, 7) == 0) it.sample = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
        return it;
    endfunction

    t_row directed[$];

    initial begin
        t_item it;
        drive_reg = 18'sd49152; slope_reg = 18'sd32768;
        drive_sel = 1'b0; slope_sel = 1'b0; prev_out = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, clipping, zero sample, mode bits
        directed.push_back('{'{18'sd0, 18'sd0, 24'sd0}, 1'b0, 32'd0});
        directed.push_back('{'{18'sd0, 18'sd0, 24'sh7fffff}, 1'b0, 32'd0});
        directed.push_back('{'{18'sd0, 18'sd0, 24'sh800000}, 1'b0, 32'd0});
        directed.push_back('{'{18'sh1ffff, 18'sh20000, 24'sd1}, 1'b0, 32'd0});
        directed.push_back('{'{18'sh20000, 18'sh1ffff, -24'sd1}, 1'b0, 32'd0});
        foreach (directed[k]) begin
            send_sample(directed[k].item, directed[k].has_fixed, directed[k].fixed_out);
        end
        drain_results();

        write_reg(REG_DRIVE_SEL, 18'd1);
        write_reg(REG_SLOPE_SEL, 18'd1);
        directed.delete();
        directed.push_back('{'{18'sd65536, 18'sd65536, 24'sh7fffff}, 1'b0, 32'd0});
        directed.push_back('{'{18'sd65536, 18'sd65536, 24'sh7fffff}, 1'b0, 32'd0});
        directed.push_back('{'{18'sd65536, 18'sd65536, 24'sh7fffff}, 1'b0, 32'd0});
        directed.push_back('{'{18'sh20000, 18'sh20000, 24'sh800000}, 1'b0, 32'd0});
        directed.push_back('{'{18'sh1ffff, 18'sh1ffff, 24'sh800000}, 1'b0, 32'd0});
        directed.push_back('{'{18'sd65537, 18'sd0, 24'sh555555}, 1'b0, 32'd0});
        directed.push_back('{'{18'sd0, 18'sd65535, 24'shaaaaaa}, 1'b0, 32'd0});
        directed.push_back('{'{18'sd1, 18'sd1, 24'sd0}, 1'b0, 32'd0});
        foreach (directed[k]) begin
            send_sample(directed[k].item, directed[k].has_fixed, directed[k].fixed_out);
        end
        drain_results();

        // random phases through several register settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_DRIVE_VALUE, 18'h20000); write_reg(REG_SLOPE_VALUE, 18'h1ffff);
                    write_reg(REG_DRIVE_SEL, 18'd0); write_reg(REG_SLOPE_SEL, 18'd0);
                end
                1: begin
                    write_reg(REG_DRIVE_VALUE, 18'd0); write_reg(REG_SLOPE_VALUE, 18'd65536);
                end
                2: begin
                    write_reg(REG_DRIVE_VALUE, 18'd65536); write_reg(REG_SLOPE_VALUE, 18'd0);
                    write_reg(REG_SLOPE_SEL, 18'd1);
                end
                3: begin
                    write_reg(REG_DRIVE_SEL, 18'd1); write_reg(REG_SLOPE_SEL, 18'd0);
                    write_reg(REG_SLOPE_VALUE, CTRL_W'($urandom));
                end
                4: begin
                    write_reg(REG_DRIVE_SEL, 18'd1); write_reg(REG_SLOPE_SEL, 18'd1);
                end
                default: begin
                    write_reg(REG_DRIVE_SEL, 18'd0); write_reg(REG_SLOPE_SEL, 18'd0);
                    write_reg(REG_DRIVE_VALUE, CTRL_W'($urandom));
                    write_reg(REG_SLOPE_VALUE, CTRL_W'($urandom));
                end
            endcase
            for (int n = 0; n < N_RANDOM / 6; n++) begin
                it = rand_item();
                send_sample(it, 1'b0, 32'd0);
                random_gap();
                // hold until the pipe is empty once per phase
                if (n == 40) begin
                    s_axis_tvalid <= 1'b0;
                    while (expected_out.size() != 0) @(posedge i_clk);
                end
            end
            drain_results();
        end

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
